### rtl/mrt_pkg.sv
// Shared types, codes and attribute decode for the MPU region table.
// No dependencies; every other file of the block but mrt_ram imports this package.
package mrt_pkg;

  localparam int unsigned DefTableDepth = 32;
  localparam int unsigned DefFrameBits  = 36;
  localparam int unsigned MappedW       = 36;

  localparam logic OpInsert = 1'b0;
  localparam logic OpLookup = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_UNMAPPED = 2'd2,
    ST_BADTYPE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    MT_INVALID  = 3'd0,
    MT_RAM_RW   = 3'd1,
    MT_RAM_RO   = 3'd2,
    MT_DEV_RW   = 3'd3,
    MT_MMIO_DEV = 3'd4
  } mem_type_e;

  typedef enum logic [1:0] {
    AP_RW_ANY = 2'd0,
    AP_RO_ANY = 2'd1,
    AP_RW_HYP = 2'd2
  } access_perm_e;

  typedef struct packed {
    logic         xn;
    access_perm_e ap;
    logic         outer_sh;
    logic         device;
  } attr_t;

  typedef struct packed {
    status_e      status;
    logic [MappedW-1:0] mapped_frame;
    logic [2:0]   region_type;
    logic         region_enabled;
    logic         exec_never;
    logic [1:0]   access_perm;
    logic         outer_shareable;
    logic         device_memory;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic decide;
    logic scan;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_needed;
    logic scan_done;
  } sts_t;

  function automatic attr_t type_attr(logic [2:0] kind);
    attr_t a;
    a = '{xn: 1'b1, ap: AP_RO_ANY, outer_sh: 1'b0, device: 1'b0};
    unique case (kind)
      MT_INVALID:  a = '{xn: 1'b1, ap: AP_RO_ANY, outer_sh: 1'b0, device: 1'b0};
      MT_RAM_RW:   a = '{xn: 1'b0, ap: AP_RW_ANY, outer_sh: 1'b0, device: 1'b0};
      MT_RAM_RO:   a = '{xn: 1'b0, ap: AP_RO_ANY, outer_sh: 1'b0, device: 1'b0};
      MT_DEV_RW:   a = '{xn: 1'b1, ap: AP_RW_HYP, outer_sh: 1'b1, device: 1'b1};
      MT_MMIO_DEV: a = '{xn: 1'b1, ap: AP_RW_ANY, outer_sh: 1'b1, device: 1'b1};
      default:     a = '{xn: 1'b1, ap: AP_RO_ANY, outer_sh: 1'b0, device: 1'b0};
    endcase
    return a;
  endfunction

endpackage

### rtl/mrt_if.sv
// Valid/ready channel interfaces for MPU region table requests and responses.
// Depends on mrt_pkg for the response field widths.
interface mrt_req_if #(
  parameter int unsigned FRAME_BITS = 36
);
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [FRAME_BITS-1:0] start_frame;
  logic [FRAME_BITS-1:0] frame_count;
  logic [2:0]            mem_type;

  modport source (output valid, operation, start_frame, frame_count, mem_type,
                  input ready);
  modport sink   (input valid, operation, start_frame, frame_count, mem_type,
                  output ready);
endinterface

interface mrt_rsp_if;
  import mrt_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [MappedW-1:0] mapped_frame;
  logic [2:0]         region_type;
  logic               region_enabled;
  logic               exec_never;
  logic [1:0]         access_perm;
  logic               outer_shareable;
  logic               device_memory;

  modport source (output valid, status, mapped_frame, region_type, region_enabled,
                  exec_never, access_perm, outer_shareable, device_memory,
                  input ready);
  modport sink   (input valid, status, mapped_frame, region_type, region_enabled,
                  exec_never, access_perm, outer_shareable, device_memory,
                  output ready);
endinterface

### rtl/mrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mrt_ctrl.sv
// Sequencing state machine of the MPU region table.
// Depends on mrt_pkg for the command and status structs.
module mrt_ctrl import mrt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   out_vld_q;
  logic   slot_free;

  assign slot_free   = !out_vld_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_vld_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:   cmd_o.latch    = req_valid_i;
      S_DECIDE: cmd_o.decide   = 1'b1;
      S_SCAN:   cmd_o.scan     = 1'b1;
      S_FINISH: cmd_o.load_out = slot_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      // In the finish state a taken response is replaced by the new one below.
      if (out_vld_q && rsp_ready_i && state_q != S_FINISH) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_q <= sts_i.scan_needed ? S_SCAN : S_FINISH;
        end
        S_SCAN: begin
          if (sts_i.scan_done) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/mrt_dp.sv
// Datapath of the MPU region table: request registers, region RAM, bounds,
// scan counter and response register. Depends on mrt_pkg and mrt_ram.
module mrt_dp import mrt_pkg::*; #(
  parameter int unsigned TableDepth = DefTableDepth,
  parameter int unsigned FrameBits  = DefFrameBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 operation_i,
  input  logic [FrameBits-1:0] start_frame_i,
  input  logic [FrameBits-1:0] frame_count_i,
  input  logic [2:0]           mem_type_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output rsp_t                 rsp_o
);

  localparam int unsigned AddrW  = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW   = $clog2(TableDepth + 1);
  localparam int unsigned EndW   = FrameBits + 1;
  localparam int unsigned EntryW = FrameBits + EndW + 3;

  // Request registers.
  logic                 op_q;
  logic [FrameBits-1:0] s_q;
  logic [EndW-1:0]      e_q;
  logic [2:0]           kind_q;

  // Table state.
  logic [CntW-1:0]      count_q;
  logic [EndW-1:0]      hi_end_q;
  logic [FrameBits-1:0] lo_start_q;
  logic [CntW-1:0]      idx_q;
  logic                 cmp_vld_q;

  // Pending result.
  status_e              res_st_q;
  logic [2:0]           res_kind_q;
  rsp_t                 rsp_q;
  rsp_t                 rsp_d;

  logic                 bad_type, full, oob, hit, can_issue, do_write;
  logic [EntryW-1:0]    wdata, rdata;
  logic [FrameBits-1:0] rd_first;
  logic [EndW-1:0]      rd_end;
  logic [2:0]           rd_kind;
  attr_t                attr;

  assign bad_type  = (kind_q > MT_MMIO_DEV);
  assign full      = (count_q >= CntW'(TableDepth));
  assign oob       = (e_q > hi_end_q) || (s_q < lo_start_q);
  assign do_write  = cmd_i.decide && (op_q == OpInsert) && !bad_type && !full;
  assign wdata     = {s_q, e_q, kind_q};
  assign {rd_first, rd_end, rd_kind} = rdata;
  assign hit       = cmp_vld_q && (s_q >= rd_first) && (e_q <= rd_end);
  assign can_issue = (idx_q < count_q);

  assign sts_o.scan_needed = (op_q == OpLookup) && !oob;
  assign sts_o.scan_done   = hit || (!cmp_vld_q && !can_issue);

  mrt_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (wdata),
    .re_i    (cmd_i.scan && !hit && can_issue),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= operation_i;
      s_q    <= start_frame_i;
      e_q    <= {1'b0, start_frame_i} + {1'b0, frame_count_i};
      kind_q <= mem_type_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      hi_end_q   <= '0;
      lo_start_q <= '1;
      idx_q      <= '0;
      cmp_vld_q  <= 1'b0;
    end else begin
      if (do_write) begin
        count_q <= count_q + CntW'(1);
        if (e_q > hi_end_q) begin
          hi_end_q <= e_q;
        end
        if (s_q < lo_start_q) begin
          lo_start_q <= s_q;
        end
      end
      if (cmd_i.decide) begin
        idx_q     <= '0;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.scan) begin
        if (hit) begin
          cmp_vld_q <= 1'b0;
        end else if (can_issue) begin
          idx_q     <= idx_q + CntW'(1);
          cmp_vld_q <= 1'b1;
        end else begin
          cmp_vld_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      res_kind_q <= kind_q;
      if (op_q == OpInsert) begin
        priority if (bad_type) begin
          res_st_q <= ST_BADTYPE;
        end else if (full) begin
          res_st_q <= ST_FULL;
        end else begin
          res_st_q <= ST_OK;
        end
      end else begin
        res_st_q <= ST_UNMAPPED;
      end
    end else if (cmd_i.scan && hit) begin
      res_st_q   <= ST_OK;
      res_kind_q <= rd_kind;
    end
  end

  assign attr = type_attr(res_kind_q);

  always_comb begin
    rsp_d        = '0;
    rsp_d.status = res_st_q;
    if (res_st_q == ST_OK) begin
      if (op_q == OpLookup) begin
        rsp_d.mapped_frame = MappedW'({{MappedW{1'b0}}, s_q});
        if (res_kind_q != MT_INVALID) begin
          rsp_d.region_type    = res_kind_q;
          rsp_d.region_enabled = 1'b1;
        end
      end else begin
        rsp_d.exec_never      = attr.xn;
        rsp_d.access_perm     = attr.ap;
        rsp_d.outer_shareable = attr.outer_sh;
        rsp_d.device_memory   = attr.device;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

### rtl/mpu_region_table_core.sv
// Top level of the MPU region table: protection regions with 1:1 frame map.
// Depends on mrt_pkg, mrt_if, mrt_ctrl, mrt_dp and mrt_ram.
//
// Usage. Requests arrive on req_i (valid/ready); each one gives exactly one
// response on rsp_o (valid/ready). An insert request (operation 0) appends
// the region [start_frame, start_frame + frame_count) with its memory type
// and answers with the type's attributes, or with table full or unsupported
// type. A lookup request (operation 1) first checks the range against the
// lowest mapped start and highest mapped end, then walks the regions in
// insertion order and returns the first one that holds the whole range.
//
// Sequence. An insert, like a lookup rejected by the bounds check, passes from
// acceptance through the decide and finish states to a valid response. A
// lookup that scans also passes through the scan state, which ends when a
// region read holds the range or when all filled regions have been read. The
// walk reads one RAM entry per cycle through the registered read port. The
// next request is taken once the response is written and the block is idle.
//
// Reset clears the fill count and the bounds at once; the region RAM itself
// is not cleared, since only filled entries are ever read. When the receiver
// stalls, the response waits in its output register; one more request can
// be accepted and worked on, and it holds before publishing until the
// register is free.
module mpu_region_table_core import mrt_pkg::*; #(
  parameter int unsigned TableDepth = DefTableDepth,
  parameter int unsigned FrameBits  = DefFrameBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  mrt_req_if.sink   req_i,
  mrt_rsp_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;

  // Controller: sequences accept, decide, scan and publish.
  mrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: holds the table, the bounds and the response register.
  mrt_dp #(
    .TableDepth (TableDepth),
    .FrameBits  (FrameBits)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .operation_i   (req_i.operation),
    .start_frame_i (req_i.start_frame),
    .frame_count_i (req_i.frame_count),
    .mem_type_i    (req_i.mem_type),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rsp_o         (rsp)
  );

  assign rsp_o.status          = rsp.status;
  assign rsp_o.mapped_frame    = rsp.mapped_frame;
  assign rsp_o.region_type     = rsp.region_type;
  assign rsp_o.region_enabled  = rsp.region_enabled;
  assign rsp_o.exec_never      = rsp.exec_never;
  assign rsp_o.access_perm     = rsp.access_perm;
  assign rsp_o.outer_shareable = rsp.outer_shareable;
  assign rsp_o.device_memory   = rsp.device_memory;

endmodule

### tb/tb_mpu_region_table_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for mpu_region_table_core: directed and random requests
// checked against a cycle-free prediction of the region table.
// Depends on mrt_pkg, mrt_if and the RTL of mpu_region_table_core.
module tb_mpu_region_table_core;
  import mrt_pkg::*;

  localparam int unsigned FB = DefFrameBits;
  localparam int unsigned TD = DefTableDepth;

  // Most regions sit in a band at a quarter of the frame space, so that the
  // bounds check keeps rejecting ranges below and above it for the whole run.
  localparam logic [FB-1:0] BAND = 36'h4_0000_0000;

  localparam int RANDOM_REQS  = 1750;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 50;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic          op;
    logic [FB-1:0] start;
    logic [FB-1:0] count;
    logic [2:0]    kind;
  } region_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mrt_req_if #(.FRAME_BITS(FB)) req_if ();
  mrt_rsp_if rsp_if ();

  mpu_region_table_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Driven copies of the channel signals; every block input is known from time 0.
  region_req_t drv_req  = '0;
  logic        drv_valid = 1'b0;
  logic        rx_ready  = 1'b0;

  assign req_if.valid       = drv_valid;
  assign req_if.operation   = drv_req.op;
  assign req_if.start_frame = drv_req.start;
  assign req_if.frame_count = drv_req.count;
  assign req_if.mem_type    = drv_req.kind;
  assign rsp_if.ready       = rx_ready;

  region_req_t req_pend_q[$];
  rsp_t        rsp_expect_q[$];

  int   req_total  = 0;
  int   n_acc      = 0;
  int   mismatches = 0;
  int   cycles     = 0;
  int   hold_left  = 0;
  logic hold_done  = 1'b0;
  logic req_fire   = 1'b0;

  // Predicted table state: regions in insertion order and the mapped bounds.
  logic [FB-1:0] tbl_first[TD];
  logic [FB:0]   tbl_end[TD];
  logic [2:0]    tbl_kind[TD];
  int            tbl_fill     = 0;
  logic [FB:0]   tbl_hi_end   = '0;
  logic [FB-1:0] tbl_lo_start = '1;

  // Region bounds as the stimulus generator sees them, to aim lookups at
  // regions that really are in the table.
  longint unsigned gen_first[TD];
  longint unsigned gen_end[TD];
  int              gen_fill = 0;

  // Works out the response to one request and applies its effect on the table.
  function automatic rsp_t predict_region_rsp(region_req_t r);
    rsp_t        o;
    logic [FB:0] e;
    int          hit;
    o   = '0;
    hit = -1;
    e   = {1'b0, r.start} + {1'b0, r.count};
    if (r.op == OpInsert) begin
      // An unsupported type wins over a full table; neither changes the state.
      if (r.kind > MT_MMIO_DEV) begin
        o.status = ST_BADTYPE;
      end else if (tbl_fill >= TD) begin
        o.status = ST_FULL;
      end else begin
        tbl_first[tbl_fill] = r.start;
        tbl_end[tbl_fill]   = e;
        tbl_kind[tbl_fill]  = r.kind;
        tbl_fill++;
        if (e > tbl_hi_end) tbl_hi_end = e;
        if (r.start < tbl_lo_start) tbl_lo_start = r.start;
        o.status = ST_OK;
        case (mem_type_e'(r.kind))
          MT_INVALID: begin
            o.exec_never  = 1'b1;
            o.access_perm = AP_RO_ANY;
          end
          MT_RAM_RW: begin
            o.access_perm = AP_RW_ANY;
          end
          MT_RAM_RO: begin
            o.access_perm = AP_RO_ANY;
          end
          MT_DEV_RW: begin
            o.exec_never      = 1'b1;
            o.access_perm     = AP_RW_HYP;
            o.outer_shareable = 1'b1;
            o.device_memory   = 1'b1;
          end
          default: begin
            o.exec_never      = 1'b1;
            o.access_perm     = AP_RW_ANY;
            o.outer_shareable = 1'b1;
            o.device_memory   = 1'b1;
          end
        endcase
      end
    end else begin
      if (e > tbl_hi_end || r.start < tbl_lo_start) begin
        o.status = ST_UNMAPPED;
      end else begin
        // First region in insertion order that holds the whole range.
        for (int i = 0; i < tbl_fill; i++) begin
          if (hit < 0 && r.start >= tbl_first[i] && e <= tbl_end[i]) hit = i;
        end
        if (hit < 0) begin
          o.status = ST_UNMAPPED;
        end else begin
          o.status       = ST_OK;
          o.mapped_frame = r.start;
          // A region of invalid type is found but reports type and enable clear.
          if (tbl_kind[hit] != MT_INVALID) begin
            o.region_type    = tbl_kind[hit];
            o.region_enabled = 1'b1;
          end
        end
      end
    end
    return o;
  endfunction

  function automatic logic [FB-1:0] rand_frame();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[FB-1:0];
  endfunction

  task automatic queue_req(logic op, logic [FB-1:0] s, logic [FB-1:0] n, logic [2:0] k);
    region_req_t r;
    r = '{op: op, start: s, count: n, kind: k};
    req_pend_q.push_back(r);
    if (op == OpInsert && k <= MT_MMIO_DEV && gen_fill < TD) begin
      gen_first[gen_fill] = longint'(s);
      gen_end[gen_fill]   = longint'(s) + longint'(n);
      gen_fill++;
    end
  endtask

  task automatic gen_insert();
    logic [2:0]    k;
    logic [FB-1:0] s;
    logic [FB-1:0] n;
    if ($urandom_range(99) < 85) k = 3'($urandom_range(4));
    else k = 3'($urandom_range(7, 5));
    if (gen_fill >= TD && $urandom_range(1) == 1) begin
      // The table is full, so wide values cannot move the bounds any more.
      s = rand_frame();
      n = rand_frame();
    end else begin
      s = BAND + FB'($urandom_range(32'hffff));
      n = ($urandom_range(9) == 0) ? '0 : FB'($urandom_range(32'h800, 1));
    end
    queue_req(OpInsert, s, n, k);
  endtask

  task automatic gen_lookup();
    longint unsigned s;
    longint unsigned n;
    int              sel;
    int              i;
    sel = $urandom_range(99);
    i   = 0;
    if (gen_fill == 0 && sel < 70) sel = 70;
    if (gen_fill != 0) i = $urandom_range(gen_fill - 1);
    if (sel < 55) begin
      // A range inside a known region, empty ranges included.
      s = gen_first[i] + longint'($urandom_range(32'(gen_end[i] - gen_first[i])));
      n = longint'($urandom_range(32'(gen_end[i] - s)));
    end else if (sel < 70) begin
      // A range that hugs or just overhangs the edges of a region.
      s = gen_first[i] - longint'($urandom_range(2));
      n = gen_end[i] - s + longint'($urandom_range(2));
    end else if (sel < 85) begin
      s = longint'(BAND) + longint'($urandom_range(32'h11000));
      n = longint'($urandom_range(32'h400));
    end else begin
      s = longint'(rand_frame());
      n = ($urandom_range(1) == 1) ? longint'(rand_frame()) : longint'($urandom_range(64));
    end
    queue_req(OpLookup, FB'(s), FB'(n), 3'($urandom_range(7)));
  endtask

  // Idle shares: receiver busy and sender mostly eager first, then the other way
  // round, and no idling at all in the last third of the requests.
  function automatic int tx_idle_pct();
    if (n_acc < req_total / 3) return 37;
    else if (n_acc < 2 * req_total / 3) return 72;
    return 0;
  endfunction

  function automatic int rx_idle_pct();
    if (n_acc < req_total / 3) return 72;
    else if (n_acc < 2 * req_total / 3) return 37;
    return 0;
  endfunction

  task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
    end
  endtask

  // Request side: a request is taken at a rising edge with valid and ready
  // high; its response is predicted right there, in acceptance order.
  always @(posedge clk_i) begin
    req_fire <= rst_ni && req_if.valid && req_if.ready;
    if (rst_ni && req_if.valid && req_if.ready) begin
      rsp_expect_q.push_back(predict_region_rsp(drv_req));
      n_acc++;
    end
  end

  // Driver: valid stays high with the same request until it is taken; a new
  // request or an idle cycle is chosen only once the channel is free.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || req_fire) begin
      if (req_pend_q.size() != 0 && $urandom_range(99) >= tx_idle_pct()) begin
        drv_req   <= req_pend_q.pop_front();
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off early in the run while
  // the driver keeps offering requests, so the block backs up to its input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rx_ready <= 1'b0;
    end else if (hold_left != 0) begin
      rx_ready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_acc >= HOLD_AT) begin
      rx_ready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      rx_ready <= ($urandom_range(99) >= rx_idle_pct());
    end
  end

  // Monitor: every response taken is held against the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (rsp_expect_q.size() == 0) begin
        mismatches++;
        $display("%0t: response with none expected, expected nothing, actual status %0d",
                 $time, rsp_if.status);
      end else begin
        want = rsp_expect_q.pop_front();
        check_field("status", 64'(want.status), 64'(rsp_if.status));
        check_field("mapped_frame", 64'(want.mapped_frame), 64'(rsp_if.mapped_frame));
        check_field("region_type", 64'(want.region_type), 64'(rsp_if.region_type));
        check_field("region_enabled", 64'(want.region_enabled),
                    64'(rsp_if.region_enabled));
        check_field("exec_never", 64'(want.exec_never), 64'(rsp_if.exec_never));
        check_field("access_perm", 64'(want.access_perm), 64'(rsp_if.access_perm));
        check_field("outer_shareable", 64'(want.outer_shareable),
                    64'(rsp_if.outer_shareable));
        check_field("device_memory", 64'(want.device_memory),
                    64'(rsp_if.device_memory));
      end
    end
  end

  // Watchdog: far beyond the slowest correct run, stalls included.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // Empty table: every lookup is out of bounds.
    queue_req(OpLookup, '0, '0, 3'd0);
    queue_req(OpLookup, '1, '1, 3'd7);
    // Unsupported types, with the field extremes, leave the table untouched.
    queue_req(OpInsert, '1, '1, 3'd5);
    queue_req(OpInsert, '0, 36'd1, 3'd6);
    queue_req(OpInsert, 36'h5_5555_5555, 36'hA_AAAA_AAAA, 3'd7);
    // One region of each type and a second read-write one; the read-only one
    // overlaps the first, and the last one is empty.
    queue_req(OpInsert, BAND + 36'h1000, 36'h100, MT_RAM_RW);
    queue_req(OpInsert, BAND + 36'h2000, 36'h80, MT_INVALID);
    queue_req(OpInsert, BAND + 36'h1000, 36'h400, MT_RAM_RO);
    queue_req(OpInsert, BAND + 36'h8000, 36'h10, MT_DEV_RW);
    queue_req(OpInsert, BAND + 36'h9000, 36'h20, MT_MMIO_DEV);
    queue_req(OpInsert, BAND + 36'h3000, '0, MT_RAM_RW);
    // Lookups: first match in insertion order, a region of invalid type, an
    // empty range on the empty region, both bounds, and a gap between regions.
    queue_req(OpLookup, BAND + 36'h1000, 36'h100, 3'd0);
    queue_req(OpLookup, BAND + 36'h1080, 36'h200, 3'd0);
    queue_req(OpLookup, BAND + 36'h2010, 36'h10, 3'd0);
    queue_req(OpLookup, BAND + 36'h3000, '0, 3'd0);
    queue_req(OpLookup, BAND + 36'h0fff, 36'd2, 3'd0);
    queue_req(OpLookup, BAND + 36'h9010, 36'h11, 3'd0);
    queue_req(OpLookup, BAND + 36'h5000, 36'd4, 3'd0);
    queue_req(OpLookup, BAND + 36'h8000, 36'h10, 3'd0);
    queue_req(OpLookup, BAND + 36'h901f, 36'd1, 3'd0);
    queue_req(OpLookup, '1, '0, 3'd0);

    // Random part: inserts are frequent until the table is full, then
    // mostly lookups with the odd rejected insert.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if ($urandom_range(99) < ((gen_fill < TD) ? 40 : 12)) gen_insert();
      else gen_lookup();
    end
    req_total = req_pend_q.size();

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_pend_q.size() != 0 || drv_valid) @(posedge clk_i);
    while (rsp_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && rsp_expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### mpu_region_table_core.f
rtl/mrt_pkg.sv
rtl/mrt_if.sv
rtl/mrt_ram.sv
rtl/mrt_ctrl.sv
rtl/mrt_dp.sv
rtl/mpu_region_table_core.sv
tb/tb_mpu_region_table_core.sv
